### rtl/segment_pair_intersection_assert.svh
// Assertion macros for the segment pair intersection top level.
`ifndef SEGMENT_PAIR_INTERSECTION_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_ASSERT_SVH

// Check an implication property on every clock edge outside reset.
`define SPI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("segment pair intersection check failed");

// Check that a condition never holds outside reset.
`define SPI_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("segment pair intersection forbidden condition seen");

`endif

### rtl/spi_pkg.sv
// Package with widths, types and status codes of the segment pair intersection block.
`default_nettype none
package spi_pkg;
    localparam int CW  = 16;
    localparam int FB  = 8;
    localparam int OW  = 24;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int KW  = 2 * CW + 1;
    localparam int MW  = CW;
    localparam int NW  = KW + MW;
    localparam int QW  = CW + FB;
    localparam int RW  = KW + 1;
    localparam int SL  = (KW + 1) / 2;
    localparam int SW  = ((QW > OW) ? QW : OW) + 2;
    localparam int LAT = 7 + QW;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [DW:0]     lin_t;
    typedef logic signed [2*DW-1:0] prod_t;
    typedef logic signed [PW-1:0]   cross_t;
    typedef logic [KW-1:0]          kmag_t;
    typedef logic [MW-1:0]          dmag_t;
    typedef logic [NW-1:0]          num_t;
    typedef logic [QW-1:0]          quo_t;
    typedef logic [RW-1:0]          rem_t;
    typedef logic signed [SW-1:0]   off_t;
    typedef logic signed [OW-1:0]   ocoord_t;
    typedef logic [2:0]             status_t;

    localparam status_t ST_DISJOINT     = 3'd0;
    localparam status_t ST_INTERSECTING = 3'd1;
    localparam status_t ST_PARALLEL     = 3'd2;
    localparam status_t ST_OVERLAPPING  = 3'd3;
    localparam status_t ST_DEGENERATE   = 3'd4;

    typedef struct packed {
        status_t status;
        coord_t  px;
        coord_t  py;
        logic    negx;
        logic    negy;
    } spi_tag_t;

    typedef struct packed {
        spi_tag_t tag;
        kmag_t    snmag;
        kmag_t    kmag;
        dmag_t    dxmag;
        dmag_t    dymag;
    } spi_op_t;

    typedef struct packed {
        spi_tag_t tag;
        num_t     nx;
        num_t     ny;
        kmag_t    kmag;
    } spi_num_t;

    typedef struct packed {
        spi_tag_t tag;
        quo_t     qx;
        quo_t     qy;
        logic     rx_nz;
        logic     ry_nz;
    } spi_quo_t;
endpackage
`default_nettype wire

### rtl/spi_front.sv
// Front stages: differences, cross products and classification.
`default_nettype none
module spi_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  spi_pkg::coord_t ax,
    input  spi_pkg::coord_t ay,
    input  spi_pkg::coord_t bx,
    input  spi_pkg::coord_t by,
    input  spi_pkg::coord_t cx,
    input  spi_pkg::coord_t cy,
    input  spi_pkg::coord_t dx,
    input  spi_pkg::coord_t dy,
    output logic            out_valid,
    output spi_pkg::spi_op_t op
);
    import spi_pkg::*;

    logic   s1_valid_reg;
    diff_t  d1x_reg, d1y_reg, d2x_reg, d2y_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    coord_t ax1_reg, ay1_reg, bx1_reg, by1_reg;

    logic   s2_valid_reg, degen2_reg, enz2_reg;
    prod_t  k1_reg, k2_reg, s1p_reg, s2p_reg, t1p_reg, t2p_reg;
    lin_t   tlo2_reg, thi2_reg, den2_reg;
    diff_t  d1x2_reg, d1y2_reg;
    coord_t ax2_reg, ay2_reg, bx2_reg, by2_reg;

    logic   s3_valid_reg, degen3_reg, enz3_reg;
    cross_t k_reg, sn_reg, tn_reg;
    lin_t   tlo3_reg, thi3_reg, den3_reg;
    diff_t  d1x3_reg, d1y3_reg;
    coord_t ax3_reg, ay3_reg, bx3_reg, by3_reg;

    logic    s4_valid_reg;
    spi_op_t op_reg;
    spi_op_t op_next;

    lin_t   absx, absy, t0, t1, den, t0n, t1n, denn;
    logic   xdom;
    logic   kzero, kpos, inr;
    cross_t sn_abs, k_abs;
    lin_t   dxa, dya;

    always_comb
    begin
        absx = d1x_reg[DW-1] ? -lin_t'(d1x_reg) : lin_t'(d1x_reg);
        absy = d1y_reg[DW-1] ? -lin_t'(d1y_reg) : lin_t'(d1y_reg);
        xdom = absx > absy;
        t0   = xdom ? lin_t'(ex_reg)  : lin_t'(ey_reg);
        t1   = xdom ? lin_t'(fx_reg)  : lin_t'(fy_reg);
        den  = xdom ? lin_t'(d1x_reg) : lin_t'(d1y_reg);
        t0n  = den[DW] ? -t0 : t0;
        t1n  = den[DW] ? -t1 : t1;
        denn = den[DW] ? -den : den;
    end

    always_comb
    begin
        kzero  = k_reg == '0;
        kpos   = !k_reg[PW-1];
        inr    = kpos ? (sn_reg >= 0 && sn_reg <= k_reg && tn_reg >= 0 && tn_reg <= k_reg)
                      : (sn_reg <= 0 && sn_reg >= k_reg && tn_reg <= 0 && tn_reg >= k_reg);
        sn_abs = sn_reg[PW-1] ? -sn_reg : sn_reg;
        k_abs  = k_reg[PW-1] ? -k_reg : k_reg;
        dxa    = d1x3_reg[DW-1] ? -lin_t'(d1x3_reg) : lin_t'(d1x3_reg);
        dya    = d1y3_reg[DW-1] ? -lin_t'(d1y3_reg) : lin_t'(d1y3_reg);

        op_next            = '0;
        op_next.kmag       = kmag_t'(1);
        op_next.dxmag      = dxa[MW-1:0];
        op_next.dymag      = dya[MW-1:0];
        op_next.tag.px     = ax3_reg;
        op_next.tag.py     = ay3_reg;
        op_next.tag.negx   = sn_reg[PW-1] ^ d1x3_reg[DW-1] ^ k_reg[PW-1];
        op_next.tag.negy   = sn_reg[PW-1] ^ d1y3_reg[DW-1] ^ k_reg[PW-1];
        op_next.tag.status = ST_DISJOINT;
        if (degen3_reg)
        begin
            op_next.tag.status = ST_DEGENERATE;
        end
        else if (!kzero)
        begin
            if (inr)
            begin
                op_next.tag.status = ST_INTERSECTING;
                op_next.snmag      = sn_abs[KW-1:0];
                op_next.kmag       = k_abs[KW-1:0];
            end
        end
        else if (enz3_reg && tn_reg != '0)
        begin
            op_next.tag.status = ST_PARALLEL;
        end
        else if (tlo3_reg > den3_reg || thi3_reg < 0)
        begin
            op_next.tag.status = ST_DISJOINT;
        end
        else if (thi3_reg == '0)
        begin
            op_next.tag.status = ST_INTERSECTING;
        end
        else if (tlo3_reg == den3_reg)
        begin
            op_next.tag.status = ST_INTERSECTING;
            op_next.tag.px     = bx3_reg;
            op_next.tag.py     = by3_reg;
        end
        else
        begin
            op_next.tag.status = ST_OVERLAPPING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1x_reg <= diff_t'(bx) - diff_t'(ax);
        d1y_reg <= diff_t'(by) - diff_t'(ay);
        d2x_reg <= diff_t'(dx) - diff_t'(cx);
        d2y_reg <= diff_t'(dy) - diff_t'(cy);
        ex_reg  <= diff_t'(cx) - diff_t'(ax);
        ey_reg  <= diff_t'(cy) - diff_t'(ay);
        fx_reg  <= diff_t'(dx) - diff_t'(ax);
        fy_reg  <= diff_t'(dy) - diff_t'(ay);
        ax1_reg <= ax;
        ay1_reg <= ay;
        bx1_reg <= bx;
        by1_reg <= by;

        k1_reg     <= prod_t'(d1x_reg) * prod_t'(d2y_reg);
        k2_reg     <= prod_t'(d1y_reg) * prod_t'(d2x_reg);
        s1p_reg    <= prod_t'(ex_reg) * prod_t'(d2y_reg);
        s2p_reg    <= prod_t'(ey_reg) * prod_t'(d2x_reg);
        t1p_reg    <= prod_t'(ex_reg) * prod_t'(d1y_reg);
        t2p_reg    <= prod_t'(ey_reg) * prod_t'(d1x_reg);
        degen2_reg <= (d1x_reg == '0 && d1y_reg == '0) || (d2x_reg == '0 && d2y_reg == '0);
        enz2_reg   <= ex_reg != '0 || ey_reg != '0;
        tlo2_reg   <= (t0n > t1n) ? t1n : t0n;
        thi2_reg   <= (t0n > t1n) ? t0n : t1n;
        den2_reg   <= denn;
        d1x2_reg   <= d1x_reg;
        d1y2_reg   <= d1y_reg;
        ax2_reg    <= ax1_reg;
        ay2_reg    <= ay1_reg;
        bx2_reg    <= bx1_reg;
        by2_reg    <= by1_reg;

        k_reg      <= cross_t'(k1_reg) - cross_t'(k2_reg);
        sn_reg     <= cross_t'(s1p_reg) - cross_t'(s2p_reg);
        tn_reg     <= cross_t'(t1p_reg) - cross_t'(t2p_reg);
        degen3_reg <= degen2_reg;
        enz3_reg   <= enz2_reg;
        tlo3_reg   <= tlo2_reg;
        thi3_reg   <= thi2_reg;
        den3_reg   <= den2_reg;
        d1x3_reg   <= d1x2_reg;
        d1y3_reg   <= d1y2_reg;
        ax3_reg    <= ax2_reg;
        ay3_reg    <= ay2_reg;
        bx3_reg    <= bx2_reg;
        by3_reg    <= by2_reg;

        op_reg <= op_next;
    end

    assign out_valid = s4_valid_reg;
    assign op        = op_reg;
endmodule
`default_nettype wire

### rtl/spi_mul.sv
// Two-stage split multiplier forming the division numerators.
`default_nettype none
module spi_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  spi_pkg::spi_op_t  op,
    output logic              out_valid,
    output spi_pkg::spi_num_t num
);
    import spi_pkg::*;

    logic      a_valid_reg, b_valid_reg;
    logic [SL+MW-1:0]      plo_x_reg, plo_y_reg;
    logic [KW-SL+MW-1:0]   phi_x_reg, phi_y_reg;
    spi_tag_t  tag_a_reg;
    kmag_t     k_a_reg;
    spi_num_t  num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_x_reg <= (SL+MW)'(op.snmag[SL-1:0]) * (SL+MW)'(op.dxmag);
        plo_y_reg <= (SL+MW)'(op.snmag[SL-1:0]) * (SL+MW)'(op.dymag);
        phi_x_reg <= (KW-SL+MW)'(op.snmag[KW-1:SL]) * (KW-SL+MW)'(op.dxmag);
        phi_y_reg <= (KW-SL+MW)'(op.snmag[KW-1:SL]) * (KW-SL+MW)'(op.dymag);
        tag_a_reg <= op.tag;
        k_a_reg   <= op.kmag;

        num_reg.tag  <= tag_a_reg;
        num_reg.kmag <= k_a_reg;
        num_reg.nx   <= (num_t'(phi_x_reg) << SL) + num_t'(plo_x_reg);
        num_reg.ny   <= (num_t'(phi_y_reg) << SL) + num_t'(plo_y_reg);
    end

    assign out_valid = b_valid_reg;
    assign num       = num_reg;
endmodule
`default_nettype wire

### rtl/spi_div.sv
// Pipelined restoring divider, one quotient bit per stage for both axes.
`default_nettype none
module spi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  spi_pkg::spi_num_t num,
    output logic              out_valid,
    output spi_pkg::spi_quo_t quo
);
    import spi_pkg::*;

    logic     v_reg   [QW];
    rem_t     rx_reg  [QW];
    rem_t     ry_reg  [QW];
    quo_t     lx_reg  [QW];
    quo_t     ly_reg  [QW];
    quo_t     qx_reg  [QW];
    quo_t     qy_reg  [QW];
    kmag_t    k_reg   [QW];
    spi_tag_t tag_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic     v_prev;
        rem_t     rx_prev, ry_prev, rsx, rsy;
        quo_t     lx_prev, ly_prev, qx_prev, qy_prev;
        kmag_t    k_prev;
        spi_tag_t tag_prev;
        logic     gex, gey;

        if (i == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign rx_prev  = rem_t'(num.nx[NW-1:CW]);
            assign ry_prev  = rem_t'(num.ny[NW-1:CW]);
            assign lx_prev  = quo_t'(num.nx[CW-1:0]) << FB;
            assign ly_prev  = quo_t'(num.ny[CW-1:0]) << FB;
            assign qx_prev  = '0;
            assign qy_prev  = '0;
            assign k_prev   = num.kmag;
            assign tag_prev = num.tag;
        end
        else
        begin : g_next
            assign v_prev   = v_reg[i-1];
            assign rx_prev  = rx_reg[i-1];
            assign ry_prev  = ry_reg[i-1];
            assign lx_prev  = lx_reg[i-1];
            assign ly_prev  = ly_reg[i-1];
            assign qx_prev  = qx_reg[i-1];
            assign qy_prev  = qy_reg[i-1];
            assign k_prev   = k_reg[i-1];
            assign tag_prev = tag_reg[i-1];
        end

        assign rsx = {rx_prev[RW-2:0], lx_prev[QW-1]};
        assign rsy = {ry_prev[RW-2:0], ly_prev[QW-1]};
        assign gex = rsx >= rem_t'(k_prev);
        assign gey = rsy >= rem_t'(k_prev);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[i]  <= gex ? rsx - rem_t'(k_prev) : rsx;
            ry_reg[i]  <= gey ? rsy - rem_t'(k_prev) : rsy;
            lx_reg[i]  <= lx_prev << 1;
            ly_reg[i]  <= ly_prev << 1;
            qx_reg[i]  <= {qx_prev[QW-2:0], gex};
            qy_reg[i]  <= {qy_prev[QW-2:0], gey};
            k_reg[i]   <= k_prev;
            tag_reg[i] <= tag_prev;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo.tag   = tag_reg[QW-1];
    assign quo.qx    = qx_reg[QW-1];
    assign quo.qy    = qy_reg[QW-1];
    assign quo.rx_nz = |rx_reg[QW-1];
    assign quo.ry_nz = |ry_reg[QW-1];
endmodule
`default_nettype wire

### rtl/segment_pair_intersection.sv
// Top level of the two-segment intersection classifier.
//
// Usage: drive the eight endpoint coordinates and raise start for one cycle
// per transaction; a transaction is taken at every edge where start is high
// and busy is low. busy stays low, so a new segment pair may enter every cycle.
// Each transaction gives one result: done is high for exactly one cycle with
// status, cross_x and cross_y valid in that cycle, in the order the
// transactions were taken. The pipeline has 4 front stages, 2 multiplier
// stages, 24 divider stages that resolve the fixed-point intersection one
// quotient bit per stage, and 1 output register. Every stage is registered, so
// throughput is one pair per cycle.
// cross_x and cross_y are zero unless status is intersecting.
// Reset clears all valid bits, so no result appears until a transaction
// has passed the full pipeline. The receiver cannot stall: done is a strobe.
`default_nettype none
`include "segment_pair_intersection_assert.svh"
module segment_pair_intersection (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  spi_pkg::coord_t  first_start_x,
    input  spi_pkg::coord_t  first_start_y,
    input  spi_pkg::coord_t  first_end_x,
    input  spi_pkg::coord_t  first_end_y,
    input  spi_pkg::coord_t  second_start_x,
    input  spi_pkg::coord_t  second_start_y,
    input  spi_pkg::coord_t  second_end_x,
    input  spi_pkg::coord_t  second_end_y,
    output logic             done,
    output spi_pkg::status_t status,
    output spi_pkg::ocoord_t cross_x,
    output spi_pkg::ocoord_t cross_y
);
    import spi_pkg::*;

    logic     f_valid, m_valid, d_valid;
    spi_op_t  op;
    spi_num_t num;
    spi_quo_t quo;

    logic     done_reg;
    status_t  status_reg;
    ocoord_t  cross_x_reg, cross_y_reg;
    off_t     offx, offy, sumx, sumy;

    spi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .ax        (first_start_x),
        .ay        (first_start_y),
        .bx        (first_end_x),
        .by        (first_end_y),
        .cx        (second_start_x),
        .cy        (second_start_y),
        .dx        (second_end_x),
        .dy        (second_end_y),
        .out_valid (f_valid),
        .op        (op)
    );

    spi_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .op        (op),
        .out_valid (m_valid),
        .num       (num)
    );

    spi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .num       (num),
        .out_valid (d_valid),
        .quo       (quo)
    );

    always_comb
    begin
        offx = quo.tag.negx ? -off_t'(quo.qx) - off_t'(quo.rx_nz) : off_t'(quo.qx);
        offy = quo.tag.negy ? -off_t'(quo.qy) - off_t'(quo.ry_nz) : off_t'(quo.qy);
        sumx = (off_t'(quo.tag.px) <<< FB) + offx;
        sumy = (off_t'(quo.tag.py) <<< FB) + offy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= quo.tag.status;
        if (quo.tag.status == ST_INTERSECTING)
        begin
            cross_x_reg <= sumx[OW-1:0];
            cross_y_reg <= sumy[OW-1:0];
        end
        else
        begin
            cross_x_reg <= '0;
            cross_y_reg <= '0;
        end
    end

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign status  = status_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

    `SPI_ASSERT(a_accept_gives_result, start && !busy |-> ##LAT done)
    `SPI_ASSERT(a_no_accept_no_result, !(start && !busy) |-> ##LAT !done)
    `SPI_NEVER(a_cross_zero_unless_hit,
        done && status != ST_INTERSECTING && (cross_x != '0 || cross_y != '0))
endmodule
`default_nettype wire

### bench/segment_pair_intersection_checker.sv
// Checker for the segment pair intersection block: predicts each result and compares it.
`timescale 1ns / 1ps
module segment_pair_intersection_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  spi_pkg::coord_t  first_start_x,
    input  spi_pkg::coord_t  first_start_y,
    input  spi_pkg::coord_t  first_end_x,
    input  spi_pkg::coord_t  first_end_y,
    input  spi_pkg::coord_t  second_start_x,
    input  spi_pkg::coord_t  second_start_y,
    input  spi_pkg::coord_t  second_end_x,
    input  spi_pkg::coord_t  second_end_y,
    input  logic             done,
    input  spi_pkg::status_t status,
    input  spi_pkg::ocoord_t cross_x,
    input  spi_pkg::ocoord_t cross_y,
    output int               errors,
    output int               pending
);
    import spi_pkg::*;

    typedef struct packed {
        status_t status;
        ocoord_t cx;
        ocoord_t cy;
    } verdict_t;

    verdict_t awaited_verdicts[$];

    initial errors = 0;
    assign pending = awaited_verdicts.size();

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic ocoord_t crossing_coord(input longint p, input longint d,
                                               input longint num, input longint k);
        longint prod;
        longint q;
        longint r;
        longint off;
        bit     neg;
        prod = abs64(num) * (abs64(d) << FB);
        q    = prod / abs64(k);
        r    = prod % abs64(k);
        neg  = ((num < 0) != (d < 0)) != (k < 0);
        if (q == 0 && r == 0)
            off = 0;
        else if (neg)
            off = -q - ((r != 0) ? 1 : 0);
        else
            off = q;
        return ocoord_t'(p * (longint'(1) << FB) + off);
    endfunction

    function automatic verdict_t classify(input longint ax, input longint ay,
                                          input longint bx, input longint by,
                                          input longint cx, input longint cy,
                                          input longint dx, input longint dy);
        verdict_t v;
        longint d1x, d1y, d2x, d2y, ex, ey, k, sn, tn, c, t0, t1, den, tmp;
        v   = '{ST_DISJOINT, '0, '0};
        d1x = bx - ax;
        d1y = by - ay;
        d2x = dx - cx;
        d2y = dy - cy;
        ex  = cx - ax;
        ey  = cy - ay;
        if ((d1x == 0 && d1y == 0) || (d2x == 0 && d2y == 0))
        begin
            v.status = ST_DEGENERATE;
            return v;
        end
        k = d1x * d2y - d1y * d2x;
        if (k != 0)
        begin
            sn = ex * d2y - ey * d2x;
            tn = ex * d1y - ey * d1x;
            if (k > 0 && (sn < 0 || sn > k || tn < 0 || tn > k))
                return v;
            if (k < 0 && (sn > 0 || sn < k || tn > 0 || tn < k))
                return v;
            v.status = ST_INTERSECTING;
            v.cx = crossing_coord(ax, d1x, sn, k);
            v.cy = crossing_coord(ay, d1y, sn, k);
            return v;
        end
        c = ex * d1y - ey * d1x;
        if ((ex != 0 || ey != 0) && c != 0)
        begin
            v.status = ST_PARALLEL;
            return v;
        end
        if (abs64(d1x) > abs64(d1y))
        begin
            t0  = cx - ax;
            t1  = dx - ax;
            den = d1x;
        end
        else
        begin
            t0  = cy - ay;
            t1  = dy - ay;
            den = d1y;
        end
        if (den < 0)
        begin
            den = -den;
            t0  = -t0;
            t1  = -t1;
        end
        if (t0 > t1)
        begin
            tmp = t0;
            t0  = t1;
            t1  = tmp;
        end
        if (t0 > den || t1 < 0)
            return v;
        if (t1 == 0)
        begin
            v.status = ST_INTERSECTING;
            v.cx = ocoord_t'(ax * (longint'(1) << FB));
            v.cy = ocoord_t'(ay * (longint'(1) << FB));
            return v;
        end
        if (t0 == den)
        begin
            v.status = ST_INTERSECTING;
            v.cx = ocoord_t'(bx * (longint'(1) << FB));
            v.cy = ocoord_t'(by * (longint'(1) << FB));
            return v;
        end
        v.status = ST_OVERLAPPING;
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_verdicts.size() == 0)
                    report("result with no transaction outstanding");
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (status !== want.status)
                        report($sformatf("status %0d, expected %0d", status, want.status));
                    if (cross_x !== want.cx)
                        report($sformatf("cross_x %0d, expected %0d", cross_x, want.cx));
                    if (cross_y !== want.cy)
                        report($sformatf("cross_y %0d, expected %0d", cross_y, want.cy));
                end
            end
            if (start && !busy)
                awaited_verdicts.push_back(classify(first_start_x, first_start_y,
                    first_end_x, first_end_y, second_start_x, second_start_y,
                    second_end_x, second_end_y));
        end
    end
endmodule

### bench/testbench.sv
// Top of the segment pair intersection bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import spi_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    coord_t  first_start_x = '0, first_start_y = '0, first_end_x = '0, first_end_y = '0;
    coord_t  second_start_x = '0, second_start_y = '0, second_end_x = '0, second_end_y = '0;
    logic    done;
    status_t status;
    ocoord_t cross_x, cross_y;
    int      errors, pending;
    int      cycles = 0;
    int      sent = 0;

    always #4 clk = ~clk;

    segment_pair_intersection dut (.*);

    segment_pair_intersection_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic pause_maybe();
        bit quiet;
        quiet = (sent >= 400 && sent < 600);
        while (!quiet && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_pair(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy, input int dx, input int dy);
        bit was_busy;
        pause_maybe();
        start          <= 1'b1;
        first_start_x  <= coord_t'(ax);
        first_start_y  <= coord_t'(ay);
        first_end_x    <= coord_t'(bx);
        first_end_y    <= coord_t'(by);
        second_start_x <= coord_t'(cx);
        second_start_y <= coord_t'(cy);
        second_end_x   <= coord_t'(dx);
        second_end_y   <= coord_t'(dy);
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        sent++;
    endtask

    function automatic int rnd_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic send_collinear();
        int ax, ay, ux, uy, t0, t1, s0, s1, kind;
        ax = int'($urandom_range(20000)) - 10000;
        ay = int'($urandom_range(20000)) - 10000;
        ux = int'($urandom_range(100)) - 50;
        uy = int'($urandom_range(100)) - 50;
        t1 = int'($urandom_range(200, 1));
        kind = $urandom_range(3);
        case (kind)
            0:
            begin
                s0 = 0;
                s1 = -int'($urandom_range(100, 1));
            end
            1:
            begin
                s0 = t1;
                s1 = t1 + int'($urandom_range(100, 1));
            end
            2:
            begin
                s0 = int'($urandom_range(300)) - 50;
                s1 = int'($urandom_range(300)) - 50;
            end
            default:
            begin
                s0 = t1 + int'($urandom_range(50, 1));
                s1 = s0 + int'($urandom_range(50, 1));
            end
        endcase
        if ($urandom_range(1))
        begin
            t0 = s0;
            s0 = s1;
            s1 = t0;
        end
        if ($urandom_range(3) == 0)
            send_pair(ax, ay, ax + t1 * ux, ay + t1 * uy,
                      ax + s0 * ux + uy, ay + s0 * uy - ux, ax + s1 * ux + uy, ay + s1 * uy - ux);
        else
            send_pair(ax, ay, ax + t1 * ux, ay + t1 * uy,
                      ax + s0 * ux, ay + s0 * uy, ax + s1 * ux, ay + s1 * uy);
    endtask

    task automatic send_small();
        int v[8];
        foreach (v[i]) v[i] = int'($urandom_range(12)) - 6;
        send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    initial
    begin
        int pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(0, 0, 0, 0, 1, 1, 5, 5);
        send_pair(1, 1, 5, 5, 3, 3, 3, 3);
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 10, 0, 0, 10);
        send_pair(0, 0, 7, 3, 1, 5, 6, -2);
        send_pair(0, 0, 10, 0, 0, 5, 10, 5);
        send_pair(0, 0, 10, 0, 3, 0, 20, 0);
        send_pair(0, 0, 10, 0, -5, 0, 0, 0);
        send_pair(0, 0, 10, 0, 10, 0, 15, 0);
        send_pair(0, 0, 10, 0, 15, 0, 20, 0);
        send_pair(0, 0, 0, 10, 0, 12, 0, -3);
        send_pair(0, 0, 10, 0, 20, 5, 20, -5);
        send_pair(0, 0, 10, 10, 10, 10, 20, 0);
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        send_pair(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767);
        send_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768, 0, 0, 32767, 32767);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(0, 0, 3, 1, 1, 1, 2, -1);

        repeat (1000)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_pair(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            else if (pick < 65)
                send_collinear();
            else
                send_small();
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### segment_pair_intersection.f
+incdir+rtl
rtl/spi_pkg.sv
rtl/spi_front.sv
rtl/spi_mul.sv
rtl/spi_div.sv
rtl/segment_pair_intersection.sv
bench/segment_pair_intersection_checker.sv
bench/testbench.sv
